>>> rtl/core/tqr_pkg.sv
// shared types and codes for the ticket queue with id reuse
`default_nettype none
package tqr_pkg;
	// operation codes carried in the func field
	typedef enum logic [1:0] {
		FN_ISSUE   = 2'd0,
		FN_SERVE   = 2'd1,
		FN_REMOVE  = 2'd2,
		FN_PROMOTE = 2'd3
	} func_t;

	// field widths fixed by the stream format
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned TID_W   = 8;
	localparam int unsigned RID_W   = 8;
	localparam int unsigned LEN_W   = 9;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 24;
	// wide enough to hold any id or count in the parameter range
	localparam int unsigned WIDE_W  = 17;

	// result beat fields before packing
	typedef struct packed {
		logic [RID_W-1:0] result_id;
		logic             ok;
		logic [LEN_W-1:0] line_length;
	} result_t;
endpackage
`default_nettype wire

>>> rtl/core/ticket_queue_with_id_reuse_unit.sv
// Ticket queue with id reuse: a waiting line of ids kept as a doubly linked list
// in link memories indexed by id, with a membership memory and a free-id stack.
// Input beat (s_axis): func selects issue, serve, remove or promote; ticket_id
// names the id for remove and promote. Each input beat gives exactly one output
// beat (m_axis) with the id, a success flag and the line length after the op.
// Timing: the accept cycle issues all memory reads, the next cycle does the
// read-modify-write of links, a promote passes through S_PROMO to relink the
// head, then the result goes to the output register. Promote needs S_PROMO
// because each link memory takes one write a cycle. One item is in flight at
// a time, so a new beat is taken only once the last result has been loaded
// into the output register.
// After reset the membership memory is swept to zero, one entry a cycle, and
// s_axis_tready stays low until the sweep is done.
// When the receiver stalls, the result waits in the output register and the
// next item may be accepted and worked; it then waits until the register frees.
`default_nettype none
module ticket_queue_with_id_reuse_unit
	import tqr_pkg::*;
#(
	parameter int unsigned MAX_IDS = 256
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// func [1:0], ticket_id [9:2], zero pad [15:10]
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// result_id [7:0], ok [8], line_length [17:9], zero pad [23:18]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);
	localparam int unsigned IDW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int unsigned CW  = $clog2(MAX_IDS + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_PROMO = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	// state memories
	logic [IDW-1:0] link_after  [MAX_IDS];
	logic [IDW-1:0] link_before [MAX_IDS];
	logic           in_line     [MAX_IDS];
	logic [IDW-1:0] free_stack  [MAX_IDS];

	logic [1:0]     state_q;
	logic [IDW-1:0] head_q, tail_q;
	logic [CW-1:0]  cnt_q, fc_q;
	logic           clr_q;
	logic [IDW-1:0] clr_idx_q;

	func_t          func_q;
	logic [IDW-1:0] tid_q;
	logic           inr_q;
	logic [IDW-1:0] rid_q;
	logic           ok_q;

	logic [IDW-1:0] after_rd_s1, before_rd_s1, free_rd_s1;
	logic           inl_rd_s1;

	// input decode
	func_t            in_func;
	logic [WIDE_W-1:0] in_tid_w;
	logic [IDW-1:0]   in_tid;
	logic             accept;
	logic [IDW-1:0]   la_raddr;
	logic [CW-1:0]    fc_m1;

	assign in_func  = func_t'(s_axis_tdata[FUNC_W-1:0]);
	assign in_tid_w = WIDE_W'(s_axis_tdata[FUNC_W +: TID_W]);
	assign in_tid   = in_tid_w[IDW-1:0];
	assign s_axis_tready = (state_q == S_IDLE) && !clr_q;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign la_raddr = (in_func == FN_SERVE) ? head_q : in_tid;
	assign fc_m1    = fc_q - CW'(1);

	// exec datapath
	logic           la_we, lb_we, il_we, il_wd, fs_we;
	logic [IDW-1:0] la_wa, la_wd, lb_wa, lb_wd, il_wa, fs_wa, fs_wd;
	logic [IDW-1:0] head_n, tail_n, rid_n, new_id;
	logic [CW-1:0]  cnt_n, fc_n;
	logic           ok_n, have, hit, do_unlink, go_promo;

	always_comb begin
		la_we = 1'b0; la_wa = tid_q; la_wd = head_q;
		lb_we = 1'b0; lb_wa = head_q; lb_wd = tid_q;
		il_we = 1'b0; il_wa = tid_q; il_wd = 1'b0;
		fs_we = 1'b0; fs_wa = fc_q[IDW-1:0]; fs_wd = tid_q;
		head_n = head_q; tail_n = tail_q; cnt_n = cnt_q; fc_n = fc_q;
		rid_n = rid_q; ok_n = ok_q; go_promo = 1'b0;
		have = (fc_q != '0) || (cnt_q < CW'(MAX_IDS));
		new_id = (fc_q != '0) ? free_rd_s1 : cnt_q[IDW-1:0];
		hit = inr_q && inl_rd_s1;
		do_unlink = hit && ((func_q == FN_REMOVE) || (tid_q != head_q));
		if (state_q == S_EXEC) begin
			case (func_q)
				FN_ISSUE: begin
					rid_n = '0;
					ok_n  = have;
					if (have) begin
						if (cnt_q != '0) begin
							la_we = 1'b1; la_wa = tail_q; la_wd = new_id;
							lb_we = 1'b1; lb_wa = new_id; lb_wd = tail_q;
						end else begin
							head_n = new_id;
						end
						tail_n = new_id;
						il_we = 1'b1; il_wa = new_id; il_wd = 1'b1;
						cnt_n = cnt_q + CW'(1);
						if (fc_q != '0) begin
							fc_n = fc_m1;
						end
						rid_n = new_id;
					end
				end
				FN_SERVE: begin
					rid_n = '0;
					ok_n  = (cnt_q != '0);
					if (cnt_q != '0) begin
						if (cnt_q > CW'(1)) begin
							head_n = after_rd_s1;
						end
						il_we = 1'b1; il_wa = head_q; il_wd = 1'b0;
						cnt_n = cnt_q - CW'(1);
						if (fc_q < CW'(MAX_IDS)) begin
							fs_we = 1'b1; fs_wd = head_q;
							fc_n = fc_q + CW'(1);
						end
						rid_n = head_q;
					end
				end
				default: begin
					rid_n = tid_q;
					ok_n  = hit;
					// detach the given id from its neighbors
					if (do_unlink) begin
						if ((tid_q == head_q) && (tid_q == tail_q)) begin
							head_n = head_q;
						end else if (tid_q == head_q) begin
							head_n = after_rd_s1;
						end else if (tid_q == tail_q) begin
							tail_n = before_rd_s1;
						end else begin
							la_we = 1'b1; la_wa = before_rd_s1; la_wd = after_rd_s1;
							lb_we = 1'b1; lb_wa = after_rd_s1; lb_wd = before_rd_s1;
						end
					end
					if (hit && (func_q == FN_REMOVE)) begin
						il_we = 1'b1; il_wa = tid_q; il_wd = 1'b0;
						cnt_n = cnt_q - CW'(1);
						if (fc_q < CW'(MAX_IDS)) begin
							fs_we = 1'b1; fs_wd = tid_q;
							fc_n = fc_q + CW'(1);
						end
					end
					go_promo = do_unlink && (func_q == FN_PROMOTE);
				end
			endcase
		end else if (state_q == S_PROMO) begin
			// relink the id in front of the old head
			lb_we = 1'b1; lb_wa = head_q; lb_wd = tid_q;
			la_we = 1'b1; la_wa = tid_q; la_wd = head_q;
			head_n = tid_q;
		end
	end

	// memories: reads at accept, writes during exec and promote, and the clearing sweep
	always_ff @(posedge clk) begin
		if (accept) begin
			after_rd_s1  <= link_after[la_raddr];
			before_rd_s1 <= link_before[in_tid];
			inl_rd_s1    <= in_line[in_tid];
			free_rd_s1   <= free_stack[fc_m1[IDW-1:0]];
		end
		if (la_we) begin
			link_after[la_wa] <= la_wd;
		end
		if (lb_we) begin
			link_before[lb_wa] <= lb_wd;
		end
		if (clr_q) begin
			in_line[clr_idx_q] <= 1'b0;
		end else if (il_we) begin
			in_line[il_wa] <= il_wd;
		end
		if (fs_we) begin
			free_stack[fs_wa] <= fs_wd;
		end
	end

	// output register
	logic    buf_free, buf_load;
	result_t res;

	assign buf_load = (state_q == S_DONE) && buf_free;
	assign res.result_id   = RID_W'(WIDE_W'(rid_q));
	assign res.ok          = ok_q;
	assign res.line_length = LEN_W'(WIDE_W'(cnt_q));

	tqr_out_buf u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (buf_load),
		.result        (res),
		.free          (buf_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			fc_q      <= '0;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else begin
			head_q <= head_n;
			tail_q <= tail_n;
			cnt_q  <= cnt_n;
			fc_q   <= fc_n;
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + IDW'(1);
				if (clr_idx_q == IDW'(MAX_IDS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= go_promo ? S_PROMO : S_DONE;
				end
				S_PROMO: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (buf_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= in_func;
			tid_q  <= in_tid;
			inr_q  <= in_tid_w < WIDE_W'(MAX_IDS);
		end
		if (state_q == S_EXEC) begin
			rid_q <= rid_n;
			ok_q  <= ok_n;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WIDE_W'(cnt_q) + WIDE_W'(fc_q)) <= WIDE_W'(MAX_IDS))
		else $error("line plus free ids exceed id space");
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s_axis_tready)
		else $error("item taken during clearing sweep");
	a_issue_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && func_q == FN_ISSUE && have)
		|=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("issue did not grow the line");
	a_promo_head: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROMO) |=> head_q == $past(tid_q))
		else $error("promote did not move id to head");
`endif
endmodule
`default_nettype wire

>>> rtl/core/tqr_out_buf.sv
// output register holding one result beat until the receiver takes it
`default_nettype none
module tqr_out_buf
	import tqr_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire result_t                result,
	output logic                        free,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// result_id [7:0], ok [8], line_length [17:9], zero pad [23:18]
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);
	logic    valid_q;
	result_t data_q;

	// slot is free when empty or being drained this cycle
	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W-RID_W-1-LEN_W)'(0), data_q.line_length,
		data_q.ok, data_q.result_id};
endmodule
`default_nettype wire

>>> sim/ticket_queue_with_id_reuse_unit_test.sv
// testbench for the ticket queue with id reuse: random and directed beats checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module ticket_queue_with_id_reuse_unit_test;
	import tqr_pkg::*;

	localparam int unsigned NUM_IDS = 256;
	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// func [1:0], ticket_id [9:2], zero pad [15:10]
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// result_id [7:0], ok [8], line_length [17:9], zero pad [23:18]
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	ticket_queue_with_id_reuse_unit #(.MAX_IDS(NUM_IDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// predictor copy of the line
	logic [7:0] nxt_id [NUM_IDS];
	logic [7:0] prv_id [NUM_IDS];
	bit         member [NUM_IDS];
	logic [7:0] freed_ids [$];
	logic [7:0] line_head;
	logic [7:0] line_tail;
	int unsigned line_len;

	result_t expected_results [$];
	int unsigned mismatches;
	int unsigned results_seen;
	int unsigned idle_cycles;
	int unsigned stall_left;
	bit sink_idle_on;
	bit timed_out;
	int unsigned op_counts [4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// detach a member without touching the length
	task automatic detach_ticket(input logic [7:0] id);
		if (id == line_head && id == line_tail) begin
			return;
		end
		if (id == line_head) begin
			line_head = nxt_id[id];
		end else if (id == line_tail) begin
			line_tail = prv_id[id];
		end else begin
			nxt_id[prv_id[id]] = nxt_id[id];
			prv_id[nxt_id[id]] = prv_id[id];
		end
	endtask

	// next line state and the beat it gives
	task automatic predict_ticket_op(input func_t fn, input logic [7:0] tid);
		result_t r;
		logic [7:0] id;
		bit have;
		r = '0;
		have = 1'b0;
		op_counts[fn]++;
		case (fn)
			FN_ISSUE: begin
				if (freed_ids.size() > 0) begin
					id = freed_ids.pop_back();
					have = 1'b1;
				end else if (line_len < NUM_IDS) begin
					id = line_len[7:0];
					have = 1'b1;
				end
				if (have) begin
					if (line_len == 0) begin
						line_head = id;
					end else begin
						nxt_id[line_tail] = id;
						prv_id[id] = line_tail;
					end
					line_tail = id;
					member[id] = 1'b1;
					line_len++;
					r.result_id = id;
					r.ok = 1'b1;
				end
			end
			FN_SERVE: begin
				if (line_len > 0) begin
					id = line_head;
					if (line_len > 1) begin
						line_head = nxt_id[id];
					end
					member[id] = 1'b0;
					line_len--;
					freed_ids.push_back(id);
					r.result_id = id;
					r.ok = 1'b1;
				end
			end
			default: begin
				r.result_id = tid;
				if (member[tid]) begin
					r.ok = 1'b1;
					if (fn == FN_REMOVE) begin
						detach_ticket(tid);
						member[tid] = 1'b0;
						line_len--;
						freed_ids.push_back(tid);
					end else if (tid != line_head) begin
						detach_ticket(tid);
						prv_id[line_head] = tid;
						nxt_id[tid] = line_head;
						line_head = tid;
					end
				end
			end
		endcase
		r.line_length = line_len[LEN_W-1:0];
		expected_results.push_back(r);
	endtask

	// send one beat, with a random idle burst first when asked
	task automatic send_ticket_op(input func_t fn, input logic [7:0] tid, input bit may_idle);
		int unsigned gap;
		if (may_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, tid, fn};
		predict_ticket_op(fn, tid);
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	// pick a line member, or any id if the line is empty
	function automatic logic [7:0] pick_member();
		logic [7:0] id;
		id = 8'($urandom_range(0, 255));
		if (line_len == 0) begin
			return id;
		end
		for (int unsigned k = 0; k < 4; k++) begin
			if (member[id]) begin
				return id;
			end
			id = 8'($urandom_range(0, (line_len > 8) ? line_len + 8 : 15));
		end
		return line_head;
	endfunction

	task automatic wait_until_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// empty line cases with extremes and other patterns of ticket_id
	task automatic test_empty_line();
		send_ticket_op(FN_SERVE, 8'hff, 1'b0);
		send_ticket_op(FN_REMOVE, 8'h00, 1'b0);
		send_ticket_op(FN_PROMOTE, 8'hff, 1'b0);
		send_ticket_op(FN_REMOVE, 8'haa, 1'b0);
		send_ticket_op(FN_PROMOTE, 8'h55, 1'b0);
	endtask

	// every operation on a short line, head, middle and tail
	task automatic test_basic_ops();
		for (int k = 0; k < 5; k++) send_ticket_op(FN_ISSUE, 8'hff, 1'b0);
		send_ticket_op(FN_PROMOTE, 8'd0, 1'b0);
		send_ticket_op(FN_PROMOTE, 8'd2, 1'b0);
		send_ticket_op(FN_PROMOTE, 8'd4, 1'b0);
		send_ticket_op(FN_REMOVE, 8'd1, 1'b0);
		send_ticket_op(FN_REMOVE, 8'd1, 1'b0);
		send_ticket_op(FN_REMOVE, 8'd3, 1'b0);
		send_ticket_op(FN_REMOVE, 8'd4, 1'b0);
		send_ticket_op(FN_SERVE, 8'd0, 1'b0);
		send_ticket_op(FN_ISSUE, 8'd0, 1'b0);
		send_ticket_op(FN_ISSUE, 8'd0, 1'b0);
		send_ticket_op(FN_ISSUE, 8'd0, 1'b0);
		send_ticket_op(FN_REMOVE, 8'd0, 1'b0);
		send_ticket_op(FN_PROMOTE, 8'd0, 1'b0);
		while (line_len > 0) send_ticket_op(FN_SERVE, 8'd0, 1'b0);
		wait_until_drained();
	endtask

	// fill every id, fail one issue, then shuffle and empty a full line
	task automatic test_full_line();
		while (line_len < NUM_IDS) send_ticket_op(FN_ISSUE, 8'($urandom_range(0, 255)), 1'b1);
		send_ticket_op(FN_ISSUE, 8'd0, 1'b1);
		send_ticket_op(FN_PROMOTE, 8'd255, 1'b1);
		send_ticket_op(FN_REMOVE, 8'd128, 1'b1);
		for (int k = 0; k < 30; k++) send_ticket_op(FN_REMOVE, pick_member(), 1'b1);
		while (line_len > 0) send_ticket_op(FN_SERVE, 8'd0, 1'b1);
	endtask

	// random mix aimed mostly at members, with idling unless told otherwise
	task automatic test_random_mix(input int unsigned n, input bit may_idle);
		func_t fn;
		logic [7:0] tid;
		for (int unsigned k = 0; k < n; k++) begin
			fn = func_t'($urandom_range(0, 3));
			if (line_len < 20 && $urandom_range(0, 2) == 0) begin
				fn = FN_ISSUE;
			end
			tid = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : pick_member();
			send_ticket_op(fn, tid, may_idle);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.result_id   = m_axis_tdata[7:0];
			got.ok          = m_axis_tdata[8];
			got.line_length = m_axis_tdata[17:9];
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
			end else begin
				want = expected_results.pop_front();
				if (got !== want || m_axis_tdata[23:18] !== 6'd0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch beat %0d: exp id %0d ok %0d len %0d, got id %0d ok %0d len %0d",
							results_seen, want.result_id, want.ok, want.line_length,
							got.result_id, got.ok, got.line_length);
					end
				end
			end
		end
	end

	// random receiver stall bursts while sink_idle_on is set
	always @(posedge clk) begin
		if (!arst_n || !sink_idle_on) begin
			m_axis_tready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1) begin
				m_axis_tready <= 1'b1;
			end
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 17);
			m_axis_tready <= 1'b0;
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				timed_out = 1'b1;
			end
		end
	end

	initial begin
		wait (timed_out);
		$display("ticket_queue_with_id_reuse_unit_test: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b1;
		sink_idle_on = 1'b0;
		timed_out = 1'b0;
		idle_cycles = 0;
		mismatches = 0;
		results_seen = 0;
		line_len = 0;
		line_head = '0;
		line_tail = '0;
		for (int k = 0; k < NUM_IDS; k++) member[k] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_line();
		test_basic_ops();
		sink_idle_on = 1'b1;
		test_full_line();
		test_random_mix(40, 1'b1);
		// sender holds off until every result is back
		wait_until_drained();
		test_random_mix(20, 1'b1);
		sink_idle_on = 1'b0;
		test_random_mix(25, 1'b0);
		wait_until_drained();

		$display("covered %0d results: issue %0d, serve %0d, remove %0d, promote %0d",
			results_seen, op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
		$display("line filled to all ids and emptied, with stalls on both sides; mismatches %0d",
			mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("ticket_queue_with_id_reuse_unit_test: PASS");
		end else begin
			$display("ticket_queue_with_id_reuse_unit_test: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
